[rtl/core/sdft_pkg.sv]
// Shared types and constants for the signed floor/truncate divider.
// No dependencies; imported by sdft_div_step and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sdft_pkg;

  // Port width of numerator, denominator, quotient and remainder.
  localparam int PORT_W = 64;
  // Arithmetic width; operands use the low DATA_W bits, sign-extended.
  localparam int DATA_W = 64;

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [1:0] {
    OP_TRUNC     = 2'd0,
    OP_TRUNC_REM = 2'd1,
    OP_FLOOR     = 2'd2,
    OP_FLOOR_REM = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  // One word in flight through the divide pipeline.
  typedef struct packed {
    logic    valid;
    logic    rem_only;
    logic    floor_mode;
    logic    sn;          // numerator sign
    logic    sd;          // denominator sign
    status_t status;
    word_t   den;         // original denominator, for the floor correction
    word_t   dabs;        // |denominator|
    word_t   prem;        // partial remainder
    word_t   quo;         // dividend bits shifting out, quotient bits shifting in
  } div_lane_t;

endpackage

`default_nettype wire

[rtl/core/sdft_div_step.sv]
// One registered restoring-division step: produces one quotient bit.
// Depends on sdft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdft_div_step (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire sdft_pkg::div_lane_t cur,
  output sdft_pkg::div_lane_t    nxt
);
  import sdft_pkg::*;

  word_t             shifted;
  logic [DATA_W:0]   diff;
  logic              take;
  div_lane_t         lane_next;

  always_comb begin
    shifted   = {cur.prem[DATA_W-2:0], cur.quo[DATA_W-1]};
    diff      = {1'b0, shifted} - {1'b0, cur.dabs};
    take      = ~diff[DATA_W];
    lane_next = cur;
    lane_next.prem = take ? diff[DATA_W-1:0] : shifted;
    lane_next.quo  = {cur.quo[DATA_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nxt.valid <= 1'b0;
    end else if (en) begin
      nxt <= lane_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/signed_division_floor_truncate_core.sv]
// Top level of the pipelined signed divider with truncate and floor modes.
// Depends on sdft_pkg and sdft_div_step.
`timescale 1ns / 1ps
`default_nettype none

// Stateless signed divider, one word per cycle. Each input word carries an
// opcode (truncate or floor rounding, full division or remainder only), a
// numerator and a denominator; each output word carries quotient, remainder
// and status (ok, divide by zero, overflow). The edge that accepts a word
// registers magnitudes and special-case flags; the word then passes through
// a chain of DATA_W restoring subtract stages, one per quotient bit, and is
// written to the output register after sign and floor correction. A word
// taken into the skid register during a stall waits until the stall clears.
// Throughput is one word per cycle while res_ready is high. The whole
// pipeline advances together when the output register is empty or taken;
// a one-word skid register at the input keeps op_ready off that path, so a
// word is still accepted in the cycle the output stalls. Quotient and
// remainder are zero when status is not ok; the quotient is zero in the
// remainder-only modes. In floor mode the remainder takes the denominator's
// sign. Operands use their low DATA_W bits, sign-extended.
module signed_division_floor_truncate_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                op_valid,
  output logic                                     op_ready,
  input  wire logic [1:0]                          opcode,
  input  wire logic signed [sdft_pkg::PORT_W-1:0]  numerator,
  input  wire logic signed [sdft_pkg::PORT_W-1:0]  denominator,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output logic signed [sdft_pkg::PORT_W-1:0]       quotient,
  output logic signed [sdft_pkg::PORT_W-1:0]       remainder,
  output logic [1:0]                               status
);
  import sdft_pkg::*;

  localparam word_t MIN_WORD = {1'b1, {(DATA_W-1){1'b0}}};

  // ---- pipeline advance ----
  logic en;
  assign en = ~res_valid | res_ready;

  // ---- input skid register ----
  logic       skid_valid;
  logic [1:0] skid_op;
  word_t      skid_num;
  word_t      skid_den;
  logic       accept;

  assign op_ready = ~skid_valid;
  assign accept   = op_valid & op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && accept) begin
      skid_op  <= opcode;
      skid_num <= numerator[DATA_W-1:0];
      skid_den <= denominator[DATA_W-1:0];
    end
  end

  // ---- front stage: magnitudes and special cases ----
  logic       s_valid;
  opcode_t    s_op;
  word_t      s_num;
  word_t      s_den;
  logic       s_rem_only;
  logic       s_floor;
  div_lane_t  front_next;

  always_comb begin
    s_valid = skid_valid | accept;
    s_op    = opcode_t'(skid_valid ? skid_op : opcode);
    s_num   = skid_valid ? skid_num : numerator[DATA_W-1:0];
    s_den   = skid_valid ? skid_den : denominator[DATA_W-1:0];

    case (s_op)
      OP_TRUNC:     begin s_rem_only = 1'b0; s_floor = 1'b0; end
      OP_TRUNC_REM: begin s_rem_only = 1'b1; s_floor = 1'b0; end
      OP_FLOOR:     begin s_rem_only = 1'b0; s_floor = 1'b1; end
      OP_FLOOR_REM: begin s_rem_only = 1'b1; s_floor = 1'b1; end
      default:      begin s_rem_only = 1'b0; s_floor = 1'b0; end
    endcase

    front_next.valid      = s_valid;
    front_next.rem_only   = s_rem_only;
    front_next.floor_mode = s_floor;
    front_next.sn         = s_num[DATA_W-1];
    front_next.sd         = s_den[DATA_W-1];
    front_next.den        = s_den;
    front_next.dabs       = s_den[DATA_W-1] ? (~s_den + 1'b1) : s_den;
    front_next.prem       = '0;
    front_next.quo        = s_num[DATA_W-1] ? (~s_num + 1'b1) : s_num;

    if (s_den == '0) begin
      front_next.status = ST_DIV0;
    end else if (!s_rem_only && s_num == MIN_WORD && s_den == '1) begin
      // most negative value over minus one does not fit
      front_next.status = ST_OVF;
    end else begin
      front_next.status = ST_OK;
    end
  end

  div_lane_t front;
  div_lane_t pipe [0:DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else if (en) begin
      front <= front_next;
    end
  end

  assign pipe[0] = front;

  // ---- quotient bit stages, MSB first ----
  for (genvar i = 0; i < DATA_W; i++) begin : g_step
    sdft_div_step u_step (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .cur (pipe[i]),
      .nxt (pipe[i+1])
    );
  end

  // ---- back stage: signs, floor correction, special cases ----
  div_lane_t  tail;
  word_t      qm;
  word_t      rm;
  word_t      q_trunc;
  word_t      r_trunc;
  word_t      r_floor;
  logic       fix;
  word_t      q_sel;
  word_t      r_sel;
  logic signed [DATA_W-1:0] q_reg;
  logic signed [DATA_W-1:0] r_reg;
  status_t    st_reg;

  always_comb begin
    tail    = pipe[DATA_W];
    qm      = tail.quo;
    rm      = tail.prem;
    q_trunc = (tail.sn ^ tail.sd) ? (~qm + 1'b1) : qm;
    r_trunc = tail.sn ? (~rm + 1'b1) : rm;
    // signs differ here, so den + r_trunc is den - rm or den + rm
    r_floor = tail.den + (rm ^ {DATA_W{tail.sn}}) + word_t'(tail.sn);
    fix     = tail.floor_mode & (rm != '0) & (tail.sn ^ tail.sd);
    // -qm - 1 == ~qm
    q_sel   = fix ? ~qm : q_trunc;
    r_sel   = fix ? r_floor : r_trunc;
    if (tail.status != ST_OK) begin
      q_sel = '0;
      r_sel = '0;
    end else if (tail.rem_only) begin
      q_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_reg  <= q_sel;
      r_reg  <= r_sel;
      st_reg <= tail.status;
    end
  end

  assign quotient  = PORT_W'(q_reg);
  assign remainder = PORT_W'(r_reg);
  assign status    = st_reg;

endmodule

`default_nettype wire

[tb/signed_division_floor_truncate_core_test.sv]
// Self-checking testbench for the pipelined signed divider (truncate and floor modes).
// Depends on sdft_pkg and signed_division_floor_truncate_core; reads no files.
`timescale 1ns / 1ps
`default_nettype none

module signed_division_floor_truncate_core_test;
  import sdft_pkg::*;

  typedef logic [PORT_W-1:0] port_word_t;

  // One output word: quotient, remainder, status.
  typedef struct packed {
    port_word_t quo;
    port_word_t rmd;
    status_t    st;
  } div_result_t;

  // One row of the directed table. When typed is set, res holds the expected
  // output as written here; otherwise the predictor supplies it.
  typedef struct packed {
    opcode_t     op;
    port_word_t  num;
    port_word_t  den;
    logic        typed;
    div_result_t res;
  } stim_row_t;

  localparam port_word_t MIN_WORD = {1'b1, {(PORT_W-1){1'b0}}};
  localparam port_word_t MAX_WORD = {1'b0, {(PORT_W-1){1'b1}}};
  localparam port_word_t NEG_ONE  = '1;
  localparam int RANDOM_WORDS = 1700;
  // Input acceptance to output register passes the DATA_W step stages, plus stalls.
  localparam int DRAIN_CYCLES = DATA_W + 40;

  logic       clk;
  logic       rst;
  logic       op_valid;
  logic       op_ready;
  logic [1:0] opcode;
  logic signed [PORT_W-1:0] numerator;
  logic signed [PORT_W-1:0] denominator;
  logic       res_valid;
  logic       res_ready;
  logic signed [PORT_W-1:0] quotient;
  logic signed [PORT_W-1:0] remainder;
  logic [1:0] status;

  // Side-band to the monitor: typed expectation travelling with the word.
  logic        row_typed;
  div_result_t row_expect;

  div_result_t pending_results[$];
  stim_row_t   directed_rows[$];
  int          error_count;
  int          burst_left;
  logic [31:0] ready_pattern;
  int          pattern_cycles;

  signed_division_floor_truncate_core dut (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (op_valid),
    .op_ready    (op_ready),
    .opcode      (opcode),
    .numerator   (numerator),
    .denominator (denominator),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .quotient    (quotient),
    .remainder   (remainder),
    .status      (status)
  );

  always #6 clk = ~clk;

  // Only the low DATA_W bits of an operand count; extend their sign.
  function automatic port_word_t extend_operand(port_word_t raw);
    port_word_t v;
    v = raw;
    for (int i = DATA_W; i < PORT_W; i++) v[i] = v[DATA_W-1];
    return v;
  endfunction

  // Signed division with truncate/floor rounding, full or remainder-only.
  function automatic div_result_t predict_division(opcode_t op, port_word_t num_raw,
                                                   port_word_t den_raw);
    port_word_t  n, d, an, ad, qm, rm, min_val;
    logic        rem_only, floor_mode, sn, sd;
    div_result_t res;
    n = extend_operand(num_raw);
    d = extend_operand(den_raw);
    rem_only   = op[0];
    floor_mode = op[1];
    sn = n[PORT_W-1];
    sd = d[PORT_W-1];
    // most negative DATA_W-bit value, sign-extended to the port width
    min_val = ~((port_word_t'(1) << (DATA_W - 1)) - 1);
    res = '{quo: '0, rmd: '0, st: ST_OK};
    if (d == '0) begin
      res.st = ST_DIV0;
    end else if (!rem_only && n == min_val && d == NEG_ONE) begin
      res.st = ST_OVF;
    end else begin
      an = sn ? -n : n;
      ad = sd ? -d : d;
      qm = an / ad;
      rm = an % ad;
      res.quo = (sn != sd) ? -qm : qm;
      res.rmd = sn ? -rm : rm;
      // floor: pull the quotient down when the remainder's sign disagrees
      // with the denominator's, including when truncation gave zero
      if (floor_mode && rm != '0 && sn != sd) begin
        res.quo = res.quo - 1;
        res.rmd = res.rmd + d;
      end
      if (rem_only) res.quo = '0;
    end
    return res;
  endfunction

  // Operand mix: full random, small values, edges, wide spread of magnitudes.
  function automatic port_word_t pick_operand();
    port_word_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4: v = port_word_t'($urandom_range(0, 64)) - port_word_t'(32);
      5: begin
        case ($urandom_range(0, 6))
          0: v = '0;
          1: v = port_word_t'(1);
          2: v = NEG_ONE;
          3: v = MIN_WORD;
          4: v = MAX_WORD;
          5: v = MIN_WORD + 1;
          default: v = MAX_WORD - 1;
        endcase
      end
      6, 7: v = $signed(v) >>> $urandom_range(0, PORT_W - 2);
      8: v = {{(PORT_W-16){v[15]}}, v[15:0]};
      default: begin
        v = port_word_t'(1) << $urandom_range(0, PORT_W - 1);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, port_word_t got, port_word_t want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic add_row(opcode_t op, port_word_t num, port_word_t den, logic typed,
                         port_word_t quo, port_word_t rmd, status_t st);
    directed_rows.push_back('{op: op, num: num, den: den, typed: typed,
                              res: '{quo: quo, rmd: rmd, st: st}});
  endtask

  // Present one word and hold it until taken. Words go out in bursts; between
  // bursts op_valid drops for a random gap.
  task automatic send_word(opcode_t op, port_word_t num, port_word_t den, logic typed,
                           div_result_t exp_res);
    if (burst_left == 0) begin
      op_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 30);
    end
    op_valid    <= 1'b1;
    opcode      <= op;
    numerator   <= num;
    denominator <= den;
    row_typed   <= typed;
    row_expect  <= exp_res;
    @(posedge clk);
    while (!op_ready) @(posedge clk);
    burst_left--;
  endtask

  // Receiver: res_ready follows a rotating pattern, reshuffled now and then.
  // Patterns range from never stalling to mostly stalled.
  always @(posedge clk) begin
    if (pattern_cycles == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= '1;
        1: ready_pattern <= $urandom | 32'h1;
        2: ready_pattern <= $urandom | $urandom | 32'h1;
        default: ready_pattern <= $urandom & $urandom | 32'h1;
      endcase
      pattern_cycles <= $urandom_range(20, 300);
    end else begin
      ready_pattern  <= {ready_pattern[0], ready_pattern[31:1]};
      pattern_cycles <= pattern_cycles - 1;
    end
    res_ready <= ready_pattern[0];
  end

  // Monitor: check the output word taken at this edge against the oldest
  // expectation, then log the expectation for any input word taken here.
  // Both sides sample pre-edge values, so payloads are the accepted ones.
  always @(posedge clk) begin : monitor
    div_result_t want;
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected output word", quotient, '0);
        end else begin
          want = pending_results.pop_front();
          if (quotient !== want.quo) report_mismatch("quotient", quotient, want.quo);
          if (remainder !== want.rmd) report_mismatch("remainder", remainder, want.rmd);
          if (status !== want.st)
            report_mismatch("status", port_word_t'(status), port_word_t'(want.st));
        end
      end
      if (op_valid && op_ready) begin
        if (row_typed)
          pending_results.push_back(row_expect);
        else
          pending_results.push_back(predict_division(opcode_t'(opcode), numerator,
                                                     denominator));
      end
    end
  end

  initial begin : stimulus
    port_word_t num_v, den_v;
    clk            = 1'b0;
    rst            = 1'b1;
    op_valid       = 1'b0;
    opcode         = OP_TRUNC;
    numerator      = '0;
    denominator    = '0;
    res_ready      = 1'b0;
    row_typed      = 1'b0;
    row_expect     = '0;
    ready_pattern  = '1;
    pattern_cycles = 0;
    error_count    = 0;
    burst_left     = 0;

    // Directed table. Typed rows: small cases, zero divisor, overflow,
    // edges. Rows marked 0 in the typed column go to the predictor.
    add_row(OP_TRUNC,     7,           2,         1, 3,         1,        ST_OK);
    add_row(OP_TRUNC,     -64'sd7,     2,         1, -64'sd3,   -64'sd1,  ST_OK);
    add_row(OP_FLOOR,     -64'sd7,     2,         1, -64'sd4,   1,        ST_OK);
    add_row(OP_FLOOR,     7,           -64'sd2,   1, -64'sd4,   -64'sd1,  ST_OK);
    add_row(OP_FLOOR,     -64'sd7,     -64'sd2,   1, 3,         -64'sd1,  ST_OK);
    // truncated quotient is zero but floor still has to step down
    add_row(OP_FLOOR,     -64'sd1,     5,         1, -64'sd1,   4,        ST_OK);
    add_row(OP_FLOOR_REM, 1,           -64'sd5,   1, 0,         -64'sd4,  ST_OK);
    add_row(OP_TRUNC_REM, -64'sd7,     2,         1, 0,         -64'sd1,  ST_OK);
    // zero divisor, every mode
    add_row(OP_TRUNC,     MIN_WORD,    0,         1, 0,         0,        ST_DIV0);
    add_row(OP_TRUNC_REM, MAX_WORD,    0,         1, 0,         0,        ST_DIV0);
    add_row(OP_FLOOR,     NEG_ONE,     0,         1, 0,         0,        ST_DIV0);
    add_row(OP_FLOOR_REM, 0,           0,         1, 0,         0,        ST_DIV0);
    // minimum over minus one: overflow in full modes, plain zero remainder
    // in remainder-only modes
    add_row(OP_TRUNC,     MIN_WORD,    NEG_ONE,   1, 0,         0,        ST_OVF);
    add_row(OP_FLOOR,     MIN_WORD,    NEG_ONE,   1, 0,         0,        ST_OVF);
    add_row(OP_TRUNC_REM, MIN_WORD,    NEG_ONE,   1, 0,         0,        ST_OK);
    add_row(OP_FLOOR_REM, MIN_WORD,    NEG_ONE,   1, 0,         0,        ST_OK);
    add_row(OP_TRUNC,     MAX_WORD,    MAX_WORD,  1, 1,         0,        ST_OK);
    add_row(OP_FLOOR,     MIN_WORD,    MIN_WORD,  1, 1,         0,        ST_OK);
    add_row(OP_TRUNC,     MIN_WORD,    1,         1, MIN_WORD,  0,        ST_OK);
    add_row(OP_FLOOR,     0,           NEG_ONE,   1, 0,         0,        ST_OK);
    add_row(OP_FLOOR,     MAX_WORD,    MIN_WORD,  0, 0,         0,        ST_OK);
    add_row(OP_TRUNC,     MIN_WORD,    MAX_WORD,  0, 0,         0,        ST_OK);
    add_row(OP_FLOOR,     NEG_ONE,     MIN_WORD,  0, 0,         0,        ST_OK);
    add_row(OP_FLOOR_REM, MIN_WORD,    MAX_WORD,  0, 0,         0,        ST_OK);
    add_row(OP_TRUNC,     5,           NEG_ONE,   0, 0,         0,        ST_OK);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].num, directed_rows[i].den,
                directed_rows[i].typed, directed_rows[i].res);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      num_v = pick_operand();
      den_v = ($urandom_range(0, 24) == 0) ? '0 : pick_operand();
      if ($urandom_range(0, 39) == 0) begin
        num_v = MIN_WORD;
        den_v = NEG_ONE;
      end
      send_word(opcode_t'($urandom_range(0, 3)), num_v, den_v, 1'b0, '0);
    end
    op_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // watch for stray output words after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** signed_division_floor_truncate_core: PASSED **");
    end else begin
      $display("** signed_division_floor_truncate_core: FAILED **");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("** signed_division_floor_truncate_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
